// ===== rtl/midpoint_ellipse_raster_unit_assert.svh =====
// Assertion macros shared by the ellipse rasterizer checkers.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef MIDPOINT_ELLIPSE_RASTER_UNIT_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MERU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MERU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/meru_pkg.sv =====
// Shared widths, register indexes and controller/datapath command codes
// for the midpoint ellipse rasterizer. No dependencies.
package meru_pkg;

    localparam int COORD_BITS  = 10;
    localparam int OFF_W       = COORD_BITS + 1;
    localparam int SQ_W        = 2 * COORD_BITS;
    localparam int TX_W        = COORD_BITS + 2;
    localparam int MUL_W       = 2 * TX_W;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int DEC_W       = PROD_W;
    localparam int SLOPE_W     = 4 * COORD_BITS;
    localparam int OUT_W       = 12;
    localparam int EXT_W       = (OFF_W + 1 > OUT_W) ? OFF_W + 1 : OUT_W;
    localparam int CFG_IDX_W   = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 4 * OUT_W;

    typedef logic [CFG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_CENTRE_X = 4'd0;
    localparam t_reg_idx REG_CENTRE_Y = 4'd1;
    localparam t_reg_idx REG_RADIUS_X = 4'd2;
    localparam t_reg_idx REG_RADIUS_Y = 4'd3;

    // multiplier operand pairs
    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_RX2_RY  = 3'd0;
    localparam t_mul_sel MUL_TX_TX   = 3'd1;
    localparam t_mul_sel MUL_RY2_P   = 3'd2;
    localparam t_mul_sel MUL_YM_YM   = 3'd3;
    localparam t_mul_sel MUL_RX2_P   = 3'd4;
    localparam t_mul_sel MUL_RX2_RY2 = 3'd5;

    // accumulator operations
    typedef logic [2:0] t_acc_op;
    localparam t_acc_op ACC_HOLD    = 3'd0;
    localparam t_acc_op ACC_RS_SEED = 3'd1;
    localparam t_acc_op ACC_LOAD    = 3'd2;
    localparam t_acc_op ACC_ADD4    = 3'd3;
    localparam t_acc_op ACC_SUB4    = 3'd4;

    // curve state updates
    typedef logic [2:0] t_step_op;
    localparam t_step_op STEP_NONE  = 3'd0;
    localparam t_step_op STEP_START = 3'd1;
    localparam t_step_op STEP_R1    = 3'd2;
    localparam t_step_op STEP_R2    = 3'd3;
    localparam t_step_op STEP_SEED  = 3'd4;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        t_step_op step_op;
        logic     emit;     // load the output register this cycle
        logic     emit_r2;  // region-two point, uses the stepped offsets
    } t_dp_cmd;

    typedef struct packed {
        logic slope_lt;   // slope_x_term < slope_y_term
        logic oy_zero;    // offset_y == 0
        logic slot_free;  // output register can take a beat
    } t_dp_stat;

endpackage

// ===== rtl/meru_dp.sv =====
// Datapath: configuration registers, curve state, shared multiplier,
// seed accumulator and output register. Depends on meru_pkg.
module meru_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [meru_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [meru_pkg::COORD_BITS-1:0]   i_cfg_data,
    input  meru_pkg::t_dp_cmd                 i_cmd,
    output meru_pkg::t_dp_stat                o_stat,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [meru_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                              o_m_tlast,
    output logic                              o_m_tuser
);
    import meru_pkg::*;

    function automatic logic signed [DEC_W-1:0] ext_slope(input logic signed [SLOPE_W-1:0] v);
        ext_slope = {{(DEC_W-SLOPE_W){v[SLOPE_W-1]}}, v};
    endfunction

    logic [COORD_BITS-1:0]      r_centre_x, r_centre_y, r_radius_x, r_radius_y;
    logic [SQ_W-1:0]            r_rx2, r_ry2;
    logic [OFF_W-1:0]           r_ox, r_oy, n_ox, n_oy;
    logic signed [SLOPE_W-1:0]  r_sx, r_sy, n_sx, n_sy;
    logic signed [DEC_W-1:0]    r_dec, n_dec, r_acc, n_acc;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_out_valid, r_out_last, r_out_r2;
    logic [OUT_TDATA_W-1:0]     r_out_data;

    logic signed [DEC_W-1:0]    w_rx2_d, w_ry2_d, w_prod_d, w_prod4, w_acc_adj, w_quarter;
    logic signed [SLOPE_W-1:0]  w_rx2x2_s, w_ry2x2_s, w_sx_inc, w_sy_dec;
    logic                       w_dec_neg, w_dec_pos;
    logic [OFF_W-1:0]           w_r2_ox, w_r2_oy, w_eo_x, w_eo_y, w_ym_abs;
    logic [TX_W-1:0]            w_tx;
    logic [MUL_W-1:0]           w_mul_a, w_mul_b;
    logic [EXT_W-1:0]           w_cx_e, w_cy_e, w_ox_e, w_oy_e;
    logic [EXT_W-1:0]           w_lx, w_rx, w_uy, w_ly;

    // configuration registers and radius squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x <= '0;
            r_centre_y <= '0;
            r_radius_x <= COORD_BITS'(1);
            r_radius_y <= COORD_BITS'(1);
            r_rx2      <= SQ_W'(1);
            r_ry2      <= SQ_W'(1);
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CENTRE_X: r_centre_x <= i_cfg_data;
                    REG_CENTRE_Y: r_centre_y <= i_cfg_data;
                    REG_RADIUS_X: r_radius_x <= i_cfg_data;
                    REG_RADIUS_Y: r_radius_y <= i_cfg_data;
                    default: ;
                endcase
            end
            r_rx2 <= SQ_W'(r_radius_x) * SQ_W'(r_radius_x);
            r_ry2 <= SQ_W'(r_radius_y) * SQ_W'(r_radius_y);
        end
    end

    assign w_rx2_d   = $signed({{(DEC_W-SQ_W){1'b0}}, r_rx2});
    assign w_ry2_d   = $signed({{(DEC_W-SQ_W){1'b0}}, r_ry2});
    assign w_rx2x2_s = $signed({{(SLOPE_W-SQ_W-1){1'b0}}, r_rx2, 1'b0});
    assign w_ry2x2_s = $signed({{(SLOPE_W-SQ_W-1){1'b0}}, r_ry2, 1'b0});
    assign w_prod_d  = $signed(r_prod);
    assign w_prod4   = $signed({r_prod[DEC_W-3:0], 2'b00});

    assign w_sx_inc  = r_sx + w_ry2x2_s;
    assign w_sy_dec  = r_sy - w_rx2x2_s;
    assign w_dec_neg = r_dec[DEC_W-1];
    assign w_dec_pos = !w_dec_neg && (r_dec != '0);

    // region-two step offsets, also what a region-two beat shows
    assign w_r2_oy = r_oy - OFF_W'(1);
    assign w_r2_ox = w_dec_pos ? r_ox : r_ox + OFF_W'(1);

    // seed = v/4 truncated toward zero: bias negatives by 3 before the shift
    assign w_acc_adj = r_acc + $signed({{(DEC_W-2){1'b0}}, r_acc[DEC_W-1], r_acc[DEC_W-1]});
    assign w_quarter = w_acc_adj >>> 2;

    // shared multiplier
    assign w_tx     = {r_ox, 1'b1};
    assign w_ym_abs = (r_oy == '0) ? OFF_W'(1) : r_oy - OFF_W'(1);

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_RX2_RY: begin
                w_mul_a = MUL_W'(r_rx2);
                w_mul_b = MUL_W'(r_radius_y);
            end
            MUL_TX_TX: begin
                w_mul_a = MUL_W'(w_tx);
                w_mul_b = MUL_W'(w_tx);
            end
            MUL_RY2_P: begin
                w_mul_a = MUL_W'(r_ry2);
                w_mul_b = r_prod[MUL_W-1:0];
            end
            MUL_YM_YM: begin
                w_mul_a = MUL_W'(w_ym_abs);
                w_mul_b = MUL_W'(w_ym_abs);
            end
            MUL_RX2_P: begin
                w_mul_a = MUL_W'(r_rx2);
                w_mul_b = r_prod[MUL_W-1:0];
            end
            MUL_RX2_RY2: begin
                w_mul_a = MUL_W'(r_rx2);
                w_mul_b = MUL_W'(r_ry2);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.acc_op)
            ACC_RS_SEED: n_acc = (w_ry2_d <<< 2) - w_prod4 + w_rx2_d;
            ACC_LOAD:    n_acc = w_prod_d;
            ACC_ADD4:    n_acc = r_acc + w_prod4;
            ACC_SUB4:    n_acc = r_acc - w_prod4;
            default:     n_acc = r_acc;
        endcase
    end

    always_comb begin
        n_ox  = r_ox;
        n_oy  = r_oy;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_dec = r_dec;
        case (i_cmd.step_op)
            STEP_START: begin
                n_ox = '0;
                n_oy = OFF_W'(r_radius_y);
                n_sx = '0;
                n_sy = $signed({r_prod[SLOPE_W-2:0], 1'b0});
            end
            STEP_R1: begin
                n_ox = r_ox + OFF_W'(1);
                n_sx = w_sx_inc;
                if (w_dec_neg) begin
                    n_dec = r_dec + w_ry2_d + ext_slope(w_sx_inc);
                end else begin
                    n_oy  = r_oy - OFF_W'(1);
                    n_sy  = w_sy_dec;
                    n_dec = r_dec + w_ry2_d + ext_slope(w_sx_inc) - ext_slope(w_sy_dec);
                end
            end
            STEP_R2: begin
                n_oy = w_r2_oy;
                n_sy = w_sy_dec;
                n_ox = w_r2_ox;
                if (w_dec_pos) begin
                    n_dec = r_dec + w_rx2_d - ext_slope(w_sy_dec);
                end else begin
                    n_sx  = w_sx_inc;
                    n_dec = r_dec + w_rx2_d + ext_slope(w_sx_inc) - ext_slope(w_sy_dec);
                end
            end
            STEP_SEED: n_dec = w_quarter;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        r_acc  <= n_acc;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_dec  <= n_dec;
    end

    // mirrored coordinates, wrapped to the output width
    assign w_eo_x = i_cmd.emit_r2 ? w_r2_ox : r_ox;
    assign w_eo_y = i_cmd.emit_r2 ? w_r2_oy : r_oy;
    assign w_cx_e = EXT_W'(r_centre_x);
    assign w_cy_e = EXT_W'(r_centre_y);
    assign w_ox_e = EXT_W'(w_eo_x);
    assign w_oy_e = EXT_W'(w_eo_y);
    assign w_lx   = w_cx_e - w_ox_e;
    assign w_rx   = w_cx_e + w_ox_e;
    assign w_uy   = w_cy_e - w_oy_e;
    assign w_ly   = w_cy_e + w_oy_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {w_ly[OUT_W-1:0], w_uy[OUT_W-1:0], w_rx[OUT_W-1:0], w_lx[OUT_W-1:0]};
            r_out_last <= (w_eo_y == '0);
            r_out_r2   <= i_cmd.emit_r2;
        end
    end

    assign o_stat.slope_lt  = (r_sx < r_sy);
    assign o_stat.oy_zero   = (r_oy == '0);
    assign o_stat.slot_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_r2;

endmodule

// ===== rtl/meru_ctrl.sv =====
// Controller: curve phase and the sequencer that drives the datapath
// through restart, point steps and the region-change seed. Depends on meru_pkg.
module meru_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic                i_restart,
    input  meru_pkg::t_dp_stat  i_stat,
    output meru_pkg::t_dp_cmd   o_cmd
);
    import meru_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] ST_R1_STEP = 4'd1;
    localparam logic [ST_W-1:0] ST_R2_STEP = 4'd2;
    localparam logic [ST_W-1:0] ST_EVAL    = 4'd3;
    localparam logic [ST_W-1:0] ST_RS_MUL  = 4'd4;
    localparam logic [ST_W-1:0] ST_RS_LOAD = 4'd5;
    localparam logic [ST_W-1:0] ST_RS_SEED = 4'd6;
    localparam logic [ST_W-1:0] ST_CH_EMIT = 4'd7;
    localparam logic [ST_W-1:0] ST_CH_2    = 4'd8;
    localparam logic [ST_W-1:0] ST_CH_3    = 4'd9;
    localparam logic [ST_W-1:0] ST_CH_4    = 4'd10;
    localparam logic [ST_W-1:0] ST_CH_5    = 4'd11;
    localparam logic [ST_W-1:0] ST_CH_6    = 4'd12;
    localparam logic [ST_W-1:0] ST_CH_SEED = 4'd13;

    localparam logic [1:0] PH_DONE   = 2'd0;
    localparam logic [1:0] PH_R1     = 2'd1;
    localparam logic [1:0] PH_CHANGE = 2'd2;
    localparam logic [1:0] PH_R2     = 2'd3;

    function automatic logic [ST_W-1:0] dispatch(input logic restart, input logic [1:0] phase);
        if (restart) begin
            dispatch = ST_RS_MUL;
        end else begin
            case (phase)
                PH_R1:     dispatch = ST_R1_STEP;
                PH_CHANGE: dispatch = ST_CH_EMIT;
                PH_R2:     dispatch = ST_R2_STEP;
                default:   dispatch = ST_IDLE;
            endcase
        end
    endfunction

    logic [ST_W-1:0] r_state, n_state;
    logic [1:0]      r_phase, n_phase;
    logic            w_fin;

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        w_fin         = 1'b0;
        o_cmd.mul_sel = MUL_TX_TX;
        o_cmd.acc_op  = ACC_HOLD;
        o_cmd.step_op = STEP_NONE;
        o_cmd.emit    = 1'b0;
        o_cmd.emit_r2 = 1'b0;
        case (r_state)
            ST_IDLE: w_fin = 1'b1;
            ST_R1_STEP: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.step_op = STEP_R1;
                    n_state       = ST_EVAL;
                end
            end
            ST_R2_STEP: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_r2 = 1'b1;
                    o_cmd.step_op = STEP_R2;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                w_fin = 1'b1;
                if (r_phase == PH_R1) begin
                    n_phase = i_stat.slope_lt ? PH_R1 : PH_CHANGE;
                end else begin
                    n_phase = i_stat.oy_zero ? PH_DONE : PH_R2;
                end
            end
            ST_RS_MUL: begin
                o_cmd.mul_sel = MUL_RX2_RY;
                n_state       = ST_RS_LOAD;
            end
            ST_RS_LOAD: begin
                o_cmd.acc_op  = ACC_RS_SEED;
                o_cmd.step_op = STEP_START;
                n_state       = ST_RS_SEED;
            end
            ST_RS_SEED: begin
                w_fin         = 1'b1;
                o_cmd.step_op = STEP_SEED;
                n_phase       = i_stat.slope_lt ? PH_R1 : PH_CHANGE;
            end
            // region change: show the point, then build the p2 seed
            ST_CH_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.mul_sel = MUL_TX_TX;
                    n_state       = ST_CH_2;
                end
            end
            ST_CH_2: begin
                o_cmd.mul_sel = MUL_RY2_P;
                n_state       = ST_CH_3;
            end
            ST_CH_3: begin
                o_cmd.acc_op  = ACC_LOAD;
                o_cmd.mul_sel = MUL_YM_YM;
                n_state       = ST_CH_4;
            end
            ST_CH_4: begin
                o_cmd.mul_sel = MUL_RX2_P;
                n_state       = ST_CH_5;
            end
            ST_CH_5: begin
                o_cmd.acc_op  = ACC_ADD4;
                o_cmd.mul_sel = MUL_RX2_RY2;
                n_state       = ST_CH_6;
            end
            ST_CH_6: begin
                o_cmd.acc_op = ACC_SUB4;
                n_state      = ST_CH_SEED;
            end
            ST_CH_SEED: begin
                w_fin         = 1'b1;
                o_cmd.step_op = STEP_SEED;
                n_phase       = i_stat.oy_zero ? PH_DONE : PH_R2;
            end
            default: n_state = ST_IDLE;
        endcase

        // finishing states take the next beat and dispatch on the new phase
        if (w_fin) begin
            n_state = i_s_tvalid ? dispatch(i_restart, n_phase) : ST_IDLE;
        end
    end

    assign o_s_tready = w_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_DONE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== rtl/midpoint_ellipse_raster_unit.sv =====
// Midpoint ellipse rasterizer top level: joins controller and datapath.
// Depends on meru_pkg, meru_ctrl and meru_dp.
//
//  channel   dir  beat contents
//  s (in)    in   tdata[0] restart (1 = restart at (0, radius_y), 0 = next point)
//  m (out)   out  tdata left_x, right_x, upper_y, lower_y; tuser region two; tlast last point
//  cfg       in   index 0..3 = centre_x, centre_y, radius_x, radius_y; data = value
//
// Region one and region two points: step, then evaluate while taking the next beat. Region
// change: five products through the one shared multiplier. Restart: no output. Advance
// after the curve has ended: no output.
// Synchronous active-low reset; no clearing pass. A point step waits while the output
// register holds a beat that is not taken; the config port is always ready.
module midpoint_ellipse_raster_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [meru_pkg::IN_TDATA_W-1:0]   i_s_tdata,   // [0] restart
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [meru_pkg::OUT_TDATA_W-1:0]  o_m_tdata,   // [11:0] left_x, [23:12] right_x,
                                                           // [35:24] upper_y, [47:36] lower_y
    output logic                              o_m_tlast,   // last_point
    output logic                              o_m_tuser,   // [0] in_second_region
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [meru_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [meru_pkg::COORD_BITS-1:0]   i_cfg_data
);
    import meru_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    meru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_restart  (i_s_tdata[0]),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    meru_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

// ===== rtl/meru_checker.sv =====
// Port-level checks for the ellipse rasterizer, bound to the top level.
// Depends on meru_pkg and midpoint_ellipse_raster_unit_assert.svh.
`include "midpoint_ellipse_raster_unit_assert.svh"

module meru_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_m_valid,
    input logic                              i_m_ready,
    input logic [meru_pkg::OUT_TDATA_W-1:0]  i_m_data,
    input logic                              i_m_last,
    input logic                              i_m_user
);
    import meru_pkg::*;

    // a stalled beat keeps its payload
    `MERU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_valid && !i_m_ready, i_m_valid && $stable(i_m_data) && $stable(i_m_last) && $stable(i_m_user), "output beat changed while stalled")

    // the last point sits on the horizontal axis, so both rows match
    `MERU_ASSERT_IMP(a_last_on_axis, i_clk, i_rst_n, i_m_valid && i_m_last, i_m_data[3*OUT_W-1:2*OUT_W] == i_m_data[4*OUT_W-1:3*OUT_W], "last point not on the axis")

    // nothing is pending right after reset
    `MERU_ASSERT_IMP(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !i_m_valid, "output valid right after reset")

endmodule

bind midpoint_ellipse_raster_unit meru_checker u_meru_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_m_valid (o_m_tvalid),
    .i_m_ready (i_m_tready),
    .i_m_data  (o_m_tdata),
    .i_m_last  (o_m_tlast),
    .i_m_user  (o_m_tuser)
);
